// ----- src/stg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stg_pkg
// shared types and constants of the sine tone generator
// ----------------------------------------------------------------------------
package stg_pkg;

  localparam int PERIOD_W   = 16;
  localparam int COUNT_W    = 32;
  localparam int STEP_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // register map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP    = 2'd0,
    REG_PERIOD_LEN    = 2'd1,
    REG_TOTAL_SAMPLES = 2'd2
  } cfg_reg_e;

  localparam logic [STEP_W-1:0]   PHASE_STEP_RST    = 32'd89478485;
  localparam logic [PERIOD_W-1:0] PERIOD_LEN_RST    = 16'd48;
  localparam logic [COUNT_W-1:0]  TOTAL_SAMPLES_RST = 32'd48000;

  // q30 fixed point: one and pi/2
  localparam logic [30:0] Q_ONE       = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // floor(n/6) as (n * 43691) >> 18, exact for n below 2^17
  localparam logic [15:0] DIV6_MUL   = 16'd43691;
  localparam int          DIV6_SHIFT = 18;

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

endpackage

// ----- src/stg_quarter_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stg_quarter_rom
// quarter-wave sine table in q30, two registered read ports
// ----------------------------------------------------------------------------
module stg_quarter_rom #(
  parameter int AB = 10
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AB:0]   addr_s,
  input  logic [AB:0]   addr_c,
  output logic [30:0]   data_s,
  output logic [30:0]   data_c
);
  import stg_pkg::*;

  localparam int N = 1 << AB;

  typedef logic [30:0] rom_t [0:N];

  // taylor series to x^17 with truncating steps, x in q30
  function automatic logic [30:0] taylor_sin(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] p;
    x2  = (x * x) >> 30;
    t   = x;
    pos = x;
    neg = '0;
    t = ((t * x2) >> 30) / 64'd6;   neg = neg + t;
    t = ((t * x2) >> 30) / 64'd20;  pos = pos + t;
    t = ((t * x2) >> 30) / 64'd42;  neg = neg + t;
    t = ((t * x2) >> 30) / 64'd72;  pos = pos + t;
    t = ((t * x2) >> 30) / 64'd110; neg = neg + t;
    t = ((t * x2) >> 30) / 64'd156; pos = pos + t;
    t = ((t * x2) >> 30) / 64'd210; neg = neg + t;
    t = ((t * x2) >> 30) / 64'd272; pos = pos + t;
    if (neg >= pos) begin
      p = '0;
    end else begin
      p = pos - neg;
      if (p > 64'(Q_ONE)) p = 64'(Q_ONE);
    end
    return 31'(p);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= N; k++) begin
      r[k] = taylor_sin((64'(k) * 64'(HALF_PI_Q30)) >> AB);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data_s <= ROM[addr_s];
      data_c <= ROM[addr_c];
    end
  end

endmodule

// ----- src/stg_sine_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stg_sine_pipe
// phase to sine sample: table lookup with angle-sum interpolation, 8 stages
// ----------------------------------------------------------------------------
module stg_sine_pipe #(
  parameter int PB = 32,
  parameter int SB = 24,
  parameter int AB = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [PB-1:0]        phase_in,
  input  stg_pkg::tag_t        tag_in,
  output logic signed [SB-1:0] sample,
  output stg_pkg::tag_t        tag_out
);
  import stg_pkg::*;

  localparam int FB       = PB - 2 - AB;
  localparam int FW       = (FB > 0) ? FB : 1;
  localparam int DW       = 31 - AB;
  localparam int D2W      = 32 - 2 * AB;
  localparam int D3W_RAW  = 33 - 3 * AB;
  localparam int D3W      = (D3W_RAW > 0) ? D3W_RAW : 1;
  localparam int M2W      = 31 + DW;
  localparam int MW       = 62;
  localparam int DEPTH    = 8;

  localparam logic [PB-1:0]   FRAC_MASK = PB'((64'd1 << FB) - 64'd1);
  localparam logic [AB:0]     TAB_N     = (AB+1)'(1) << AB;
  localparam logic [MW-1:0]   HALF_LSB  = MW'(64'd1 << 29);
  localparam logic [SB-2:0]   AMP       = '1;

  // stage 2: split phase, table address, residual angle
  logic [1:0]        quad_in;
  logic [AB-1:0]     idx_in;
  logic [FW-1:0]     frac_in;
  logic [FW+30:0]    dprod;
  logic [AB:0]       addr_s;
  logic [AB:0]       addr_c;
  logic [30:0]       s_s2;
  logic [30:0]       c_s2;
  logic [DW-1:0]     d_s2_r;

  assign quad_in = phase_in[PB-1:PB-2];
  assign idx_in  = phase_in[PB-3:FB];
  assign frac_in = FW'(phase_in & FRAC_MASK);
  assign dprod   = (FW+31)'(frac_in) * (FW+31)'(HALF_PI_Q30);
  assign addr_s  = {1'b0, idx_in};
  assign addr_c  = TAB_N - addr_s;

  stg_quarter_rom #(.AB(AB)) u_rom (
    .clk    (clk),
    .en     (en),
    .addr_s (addr_s),
    .addr_c (addr_c),
    .data_s (s_s2),
    .data_c (c_s2)
  );

  // stage 3: d^2
  logic [2*DW-1:0]   ddp;
  logic [D2W-1:0]    d2_s3_r;
  logic [DW-1:0]     d_s3_r;
  logic [30:0]       s_s3_r, c_s3_r;

  assign ddp = (2*DW)'(d_s2_r) * (2*DW)'(d_s2_r);

  // stage 4: d^3 and cos d
  logic [D2W+DW-1:0] d3p;
  logic [D3W-1:0]    d3_s4_r;
  logic [30:0]       cosd_s4_r;
  logic [DW-1:0]     d_s4_r;
  logic [30:0]       s_s4_r, c_s4_r;

  assign d3p = (D2W+DW)'(d2_s3_r) * (D2W+DW)'(d_s3_r);

  // stage 5: sin d
  logic [D3W+15:0]   q6p;
  logic [DW-1:0]     sind_s5_r;
  logic [30:0]       cosd_s5_r;
  logic [30:0]       s_s5_r, c_s5_r;

  assign q6p = (D3W+16)'(d3_s4_r) * (D3W+16)'(DIV6_MUL);

  // stage 6: angle-sum products
  logic [1:0]        q_r [0:DEPTH-2];
  logic              even6;
  logic [30:0]       a1, a2;
  logic [MW-1:0]     m1_s6_r;
  logic [M2W-1:0]    m2_s6_r;

  assign even6 = ~q_r[3][0];
  assign a1    = even6 ? s_s5_r : c_s5_r;
  assign a2    = even6 ? c_s5_r : s_s5_r;

  // stage 7: sum or clamped difference
  logic              even7;
  logic [MW-1:0]     m2e;
  logic [MW-1:0]     acc_nxt;
  logic [MW-1:0]     acc_s7_r;

  assign even7 = ~q_r[4][0];
  assign m2e   = MW'(m2_s6_r);

  always_comb begin
    if (even7) begin
      acc_nxt = m1_s6_r + m2e;
    end else if (m1_s6_r > m2e) begin
      acc_nxt = m1_s6_r - m2e;
    end else begin
      acc_nxt = '0;
    end
  end

  // stage 8: round to q30 and clamp
  logic [MW-1:0]     rsum;
  logic [31:0]       rq;
  logic [30:0]       m_nxt;
  logic [30:0]       m_s8_r;

  assign rsum  = acc_s7_r + HALF_LSB;
  assign rq    = 32'(rsum >> 30);
  assign m_nxt = (rq > 32'(Q_ONE)) ? Q_ONE : 31'(rq);

  // stage 9: scale to amplitude, apply sign
  logic [SB+29:0]    magp;
  logic [SB-1:0]     mag;
  logic [SB-1:0]     sample_nxt;

  assign magp       = (SB+30)'(m_s8_r) * (SB+30)'(AMP);
  assign mag        = SB'(magp >> 30);
  assign sample_nxt = q_r[6][1] ? (~mag + SB'(1)) : mag;

  tag_t tag_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) tag_r[k] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_in;
      for (int k = 1; k < DEPTH; k++) tag_r[k] <= tag_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0] <= quad_in;
      for (int k = 1; k < DEPTH - 1; k++) q_r[k] <= q_r[k-1];

      d_s2_r    <= DW'(dprod >> (PB - 2));

      d2_s3_r   <= D2W'(ddp >> 30);
      d_s3_r    <= d_s2_r;
      s_s3_r    <= s_s2;
      c_s3_r    <= c_s2;

      d3_s4_r   <= D3W'(d3p >> 30);
      cosd_s4_r <= Q_ONE - 31'(d2_s3_r >> 1);
      d_s4_r    <= d_s3_r;
      s_s4_r    <= s_s3_r;
      c_s4_r    <= c_s3_r;

      sind_s5_r <= d_s4_r - DW'(q6p >> DIV6_SHIFT);
      cosd_s5_r <= cosd_s4_r;
      s_s5_r    <= s_s4_r;
      c_s5_r    <= c_s4_r;

      m1_s6_r   <= MW'(a1) * MW'(cosd_s5_r);
      m2_s6_r   <= M2W'(a2) * M2W'(sind_s5_r);

      acc_s7_r  <= acc_nxt;
      m_s8_r    <= m_nxt;
      sample    <= sample_nxt;
    end
  end

  assign tag_out = tag_r[DEPTH-1];

endmodule

// ----- src/sine_tone_generator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_tone_generator_unit
// direct digital synthesis tone source, at most one signed sample per tick
// ----------------------------------------------------------------------------
// a result passes the stage 1 phase register, then stages 2 to 9, into the output register
// throughput: one item per cycle, set by the 9-stage pipeline (at most one
//   multiply level per stage) with a shared stall when the output register is full
// reset: sync active low, clears tone state and pipeline valids, loads the
//   default register values, no clearing pass
module sine_tone_generator_unit #(
  parameter int PHASE_BITS      = 32,
  parameter int SAMPLE_BITS     = 24,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tick items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_start_req,
  // sample items
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     out_sample,
  output logic                              out_last,
  // register writes
  input  logic                              cfg_we,
  input  logic [stg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import stg_pkg::*;

  // configuration registers
  logic [STEP_W-1:0]   phase_step_r;
  logic [PERIOD_W-1:0] period_len_r;
  logic [COUNT_W-1:0]  total_samples_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= PHASE_STEP_RST;
      period_len_r    <= PERIOD_LEN_RST;
      total_samples_r <= TOTAL_SAMPLES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_STEP:    phase_step_r    <= cfg_wdata;
        REG_PERIOD_LEN:    period_len_r    <= cfg_wdata[PERIOD_W-1:0];
        REG_TOTAL_SAMPLES: total_samples_r <= cfg_wdata;
        default:           ;
      endcase
    end
  end

  // whole pipeline moves together unless a result is waiting
  logic en;
  logic accept;
  tag_t tag_out;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && in_ready;

  // tone sequencing
  logic [PERIOD_W-1:0] period_index_r, period_index_nxt;
  logic [COUNT_W-1:0]  emitted_count_r, emitted_count_nxt;
  logic                running_r, running_nxt;

  logic [PERIOD_W-1:0] idx_cur;
  logic [COUNT_W-1:0]  cnt_cur;
  logic                run_cur;
  logic [COUNT_W-1:0]  cnt_inc;
  logic [PERIOD_W:0]   idx_next;
  logic                period_end;
  logic                done;

  // a start item restarts the tone at phase zero in the same tick
  assign idx_cur    = in_start_req ? '0 : period_index_r;
  assign cnt_cur    = in_start_req ? '0 : emitted_count_r;
  assign run_cur    = in_start_req ? (total_samples_r != '0) : running_r;
  // count saturates at all ones
  assign cnt_inc    = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_W'(1);
  assign idx_next   = {1'b0, idx_cur} + (PERIOD_W+1)'(1);
  // zero period length ends every period, as does a shrunk length
  assign period_end = idx_next >= {1'b0, period_len_r};
  assign done       = period_end && (cnt_inc >= total_samples_r);

  always_comb begin
    period_index_nxt  = period_index_r;
    emitted_count_nxt = emitted_count_r;
    running_nxt       = running_r;
    if (accept) begin
      if (run_cur) begin
        period_index_nxt  = period_end ? '0 : idx_next[PERIOD_W-1:0];
        emitted_count_nxt = cnt_inc;
        running_nxt       = !done;
      end else begin
        period_index_nxt  = idx_cur;
        emitted_count_nxt = cnt_cur;
        running_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_index_r  <= '0;
      emitted_count_r <= '0;
      running_r       <= 1'b0;
    end else begin
      period_index_r  <= period_index_nxt;
      emitted_count_r <= emitted_count_nxt;
      running_r       <= running_nxt;
    end
  end

  // stage 1: phase = index * step, wrapping at the phase width
  logic [PERIOD_W+STEP_W-1:0] phase_prod;
  logic [PHASE_BITS-1:0]      phase_r;
  tag_t                       s1_tag_r;

  assign phase_prod = (PERIOD_W+STEP_W)'(idx_cur) * (PERIOD_W+STEP_W)'(phase_step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
    end else if (en) begin
      s1_tag_r.valid <= accept && run_cur;
      s1_tag_r.last  <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (en) phase_r <= PHASE_BITS'(phase_prod);
  end

  // stages 2 to 9: sine evaluation and output register
  stg_sine_pipe #(
    .PB (PHASE_BITS),
    .SB (SAMPLE_BITS),
    .AB (TABLE_ADDR_BITS)
  ) u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .phase_in (phase_r),
    .tag_in   (s1_tag_r),
    .sample   (out_sample),
    .tag_out  (tag_out)
  );

  assign out_valid = tag_out.valid;
  assign out_last  = tag_out.last;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for sine_tone_generator_unit: a directed table of
// register writes and ticks, then randomized tones under several idle and
// stall patterns; every sample item is checked against a bit-exact model of
// the fixed-point sine synthesis and the tone sequencing
// ----------------------------------------------------------------------------
module testbench;
  import stg_pkg::*;

  typedef longint unsigned u64_t;

  localparam int   SAMPLE_W     = 24;
  localparam int   TAB_BITS     = 10;
  localparam int   TAB_N        = 1 << TAB_BITS;
  localparam int   DRAIN_CYCLES = 20;
  localparam int   PHASES       = 12;
  localparam int   PHASE_ITEMS  = 55;
  localparam u64_t Q30_ONE      = 64'(Q_ONE);
  localparam u64_t HALF_PI      = 64'(HALF_PI_Q30);
  localparam u64_t AMPLITUDE    = (64'd1 << (SAMPLE_W - 1)) - 64'd1;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } tone_sample_t;

  typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_e;

  typedef struct {
    row_kind_e    kind;
    cfg_reg_e     reg_sel;
    logic [31:0]  value;
    logic         start;
    bit           known;
    bit           has_res;
    tone_sample_t res;
  } stim_row_t;

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic                       in_ready;
  logic                       in_start_req = 1'b0;
  logic                       out_valid;
  logic                       out_ready    = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_last;
  logic                       cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index    = REG_PHASE_STEP;
  logic [CFG_DATA_W-1:0]      cfg_wdata    = '0;

  // model state: quarter-wave table, registers and tone sequencing
  u64_t          quarter_wave [0:TAB_N];
  logic [31:0]   cfg_step  = PHASE_STEP_RST;
  logic [15:0]   cfg_len   = PERIOD_LEN_RST;
  logic [31:0]   cfg_total = TOTAL_SAMPLES_RST;
  logic [15:0]   tone_index   = '0;
  logic [31:0]   tone_count   = '0;
  logic          tone_running = 1'b0;

  tone_sample_t  expected_samples [$];
  stim_row_t     directed_rows [$];
  int            mismatch_count = 0;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;

  sine_tone_generator_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_start_req (in_start_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // sin(x) for x in [0, pi/2], q30 in and out, truncating series to x^17
  function automatic u64_t taylor_sine(u64_t x);
    u64_t x2, term, pos, neg;
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = 0;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) neg += term;
      else pos += term;
    end
    if (neg >= pos) return 0;
    pos -= neg;
    return (pos > Q30_ONE) ? Q30_ONE : pos;
  endfunction

  // quadrant select, table entry, then angle-sum interpolation on the rest
  function automatic logic [SAMPLE_W-1:0] sine_of_phase(logic [31:0] phase);
    u64_t frac, d, d2, cosd, sind, s, c, acc, m, mag, p1, p2;
    int   idx;
    idx  = phase[29:20];
    frac = phase[19:0];
    d    = (frac * HALF_PI) >> 30;
    d2   = (d * d) >> 30;
    cosd = Q30_ONE - (d2 >> 1);
    sind = d - ((d2 * d) >> 30) / 6;
    s    = quarter_wave[idx];
    c    = quarter_wave[TAB_N - idx];
    if (!phase[30]) begin
      acc = s * cosd + c * sind;
    end else begin
      p1  = c * cosd;
      p2  = s * sind;
      acc = (p1 > p2) ? p1 - p2 : 0;
    end
    m = (acc + (Q30_ONE >> 1)) >> 30;
    if (m > Q30_ONE) m = Q30_ONE;
    mag = (m * AMPLITUDE) >> 30;
    if (phase[31]) mag = -mag;
    return mag[SAMPLE_W-1:0];
  endfunction

  // one tick of the tone sequencer; returns 1 when a sample comes out
  function automatic bit advance_tone(input logic start, output tone_sample_t res);
    logic [31:0] phase;
    logic [16:0] next_index;
    res.sample = '0;
    res.last   = 1'b0;
    if (start) begin
      tone_index   = '0;
      tone_count   = '0;
      tone_running = (cfg_total != 0);
    end
    if (!tone_running) return 1'b0;
    phase      = tone_index * cfg_step;
    res.sample = sine_of_phase(phase);
    if (tone_count != 32'hFFFF_FFFF) tone_count++;
    next_index = tone_index + 17'd1;
    // a zero or shrunk period length ends the period here
    if (next_index >= {1'b0, cfg_len}) begin
      tone_index = '0;
      if (tone_count >= cfg_total) begin
        res.last     = 1'b1;
        tone_running = 1'b0;
      end
    end else begin
      tone_index = next_index[15:0];
    end
    return 1'b1;
  endfunction

  function automatic stim_row_t write_row(cfg_reg_e sel, logic [31:0] v);
    stim_row_t r;
    r = '{kind: ROW_WRITE, reg_sel: sel, value: v, start: 1'b0, known: 1'b0,
          has_res: 1'b0, res: '{sample: '0, last: 1'b0}};
    return r;
  endfunction

  function automatic stim_row_t tick_row(logic start);
    stim_row_t r;
    r = write_row(REG_PHASE_STEP, '0);
    r.kind  = ROW_TICK;
    r.start = start;
    return r;
  endfunction

  // typed expectation: either no sample, or a sample of 0
  function automatic stim_row_t known_row(logic start, bit has, logic last);
    stim_row_t r;
    r = tick_row(start);
    r.known    = 1'b1;
    r.has_res  = has;
    r.res.last = last;
    return r;
  endfunction

  task automatic write_reg(cfg_reg_e sel, logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (sel)
      REG_PHASE_STEP:    cfg_step  = v;
      REG_PERIOD_LEN:    cfg_len   = v[15:0];
      REG_TOTAL_SAMPLES: cfg_total = v;
      default: ;
    endcase
  endtask

  // stop sending, wait out every pending sample, then the pipeline tail if with_tail is set
  task automatic settle(bit with_tail);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
    if (with_tail) repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic issue_tick(logic start, bit known, bit known_has, tone_sample_t known_res);
    tone_sample_t res;
    bit           has;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_start_req <= start;
    do @(posedge clk); while (!in_ready);
    has = advance_tone(start, res);
    if (known) begin
      has = known_has;
      res = known_res;
    end
    if (has) expected_samples.push_back(res);
  endtask

  // sample checker, with random back-pressure
  always @(posedge clk) begin
    tone_sample_t exp_res;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none, got %0d last %0b",
                 $time, out_sample, out_last);
        mismatch_count++;
      end else begin
        exp_res = expected_samples.pop_front();
        if (out_sample !== exp_res.sample) begin
          $display("%0t: sample mismatch, expected %0d, got %0d",
                   $time, exp_res.sample, out_sample);
          mismatch_count++;
        end
        if (out_last !== exp_res.last) begin
          $display("%0t: last mismatch, expected %0b, got %0b",
                   $time, exp_res.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t    row;
    tone_sample_t blank;
    logic         start;
    bit           live;
    int           live_items;

    blank = '{sample: '0, last: 1'b0};
    for (int k = 0; k <= TAB_N; k++) begin
      quarter_wave[k] = taylor_sine((u64_t'(k) * HALF_PI) >> TAB_BITS);
    end

    // defaults after reset, idle tick, first phase-zero sample
    directed_rows.push_back(known_row(1'b0, 1'b0, 1'b0));
    directed_rows.push_back(known_row(1'b1, 1'b1, 1'b0));
    directed_rows.push_back(tick_row(1'b0));
    directed_rows.push_back(tick_row(1'b0));
    // restart of a running tone with zero total gives nothing
    directed_rows.push_back(write_row(REG_TOTAL_SAMPLES, 32'd0));
    directed_rows.push_back(known_row(1'b1, 1'b0, 1'b0));
    directed_rows.push_back(known_row(1'b0, 1'b0, 1'b0));
    // one-sample tone, largest step
    directed_rows.push_back(write_row(REG_PHASE_STEP, 32'hFFFF_FFFF));
    directed_rows.push_back(write_row(REG_PERIOD_LEN, 32'd1));
    directed_rows.push_back(write_row(REG_TOTAL_SAMPLES, 32'd1));
    directed_rows.push_back(known_row(1'b1, 1'b1, 1'b1));
    directed_rows.push_back(known_row(1'b0, 1'b0, 1'b0));
    // zero period length: phase stays at zero, every sample ends a period
    directed_rows.push_back(write_row(REG_PERIOD_LEN, 32'd0));
    directed_rows.push_back(write_row(REG_TOTAL_SAMPLES, 32'd3));
    directed_rows.push_back(known_row(1'b1, 1'b1, 1'b0));
    directed_rows.push_back(known_row(1'b0, 1'b1, 1'b0));
    directed_rows.push_back(known_row(1'b0, 1'b1, 1'b1));
    // quarter-turn steps: zero, peak, zero, trough
    directed_rows.push_back(write_row(REG_PHASE_STEP, 32'h4000_0000));
    directed_rows.push_back(write_row(REG_PERIOD_LEN, 32'd4));
    directed_rows.push_back(write_row(REG_TOTAL_SAMPLES, 32'd4));
    directed_rows.push_back(known_row(1'b1, 1'b1, 1'b0));
    directed_rows.push_back(tick_row(1'b0));
    directed_rows.push_back(known_row(1'b0, 1'b1, 1'b0));
    directed_rows.push_back(tick_row(1'b0));
    // longest period and total with a wrapping phase, then restart mid-tone
    directed_rows.push_back(write_row(REG_PHASE_STEP, 32'h9E37_79B9));
    directed_rows.push_back(write_row(REG_PERIOD_LEN, 32'hFFFF));
    directed_rows.push_back(write_row(REG_TOTAL_SAMPLES, 32'hFFFF_FFFF));
    directed_rows.push_back(known_row(1'b1, 1'b1, 1'b0));
    directed_rows.push_back(tick_row(1'b0));
    directed_rows.push_back(tick_row(1'b0));
    directed_rows.push_back(known_row(1'b1, 1'b1, 1'b0));
    directed_rows.push_back(tick_row(1'b0));
    directed_rows.push_back(tick_row(1'b0));
    // period shrunk below the index mid-tone, then total lowered mid-tone
    directed_rows.push_back(write_row(REG_PERIOD_LEN, 32'd2));
    directed_rows.push_back(tick_row(1'b0));
    directed_rows.push_back(tick_row(1'b0));
    directed_rows.push_back(write_row(REG_TOTAL_SAMPLES, 32'd1));
    directed_rows.push_back(tick_row(1'b0));
    directed_rows.push_back(known_row(1'b0, 1'b0, 1'b0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 33;
    recv_stall_pct = 33;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (i == 0 || directed_rows[i-1].kind == ROW_TICK) settle(1'b1);
        write_reg(row.reg_sel, row.value);
      end else begin
        issue_tick(row.start, row.known, row.has_res, row.res);
      end
    end

    // random tones, cycling through the idle patterns
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      settle(1'b1);
      case ($urandom_range(7))
        0:       write_reg(REG_PHASE_STEP, 32'd0);
        1:       write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        default: write_reg(REG_PHASE_STEP, $urandom);
      endcase
      case ($urandom_range(9))
        0:       write_reg(REG_PERIOD_LEN, 32'd0);
        1:       write_reg(REG_PERIOD_LEN, 32'hFFFF);
        2:       write_reg(REG_PERIOD_LEN, $urandom_range(65535));
        default: write_reg(REG_PERIOD_LEN, $urandom_range(12, 1));
      endcase
      case ($urandom_range(9))
        0:       write_reg(REG_TOTAL_SAMPLES, 32'd0);
        1:       write_reg(REG_TOTAL_SAMPLES, $urandom);
        2:       write_reg(REG_TOTAL_SAMPLES, 32'hFFFF_FFFF);
        default: write_reg(REG_TOTAL_SAMPLES, $urandom_range(40, 1));
      endcase
      live_items = 0;
      while (live_items < PHASE_ITEMS) begin
        // mostly start idle tones, rarely restart a running one
        if (tone_running) start = ($urandom_range(99) < 4);
        else start = ($urandom_range(99) < 85);
        live = start || tone_running;
        issue_tick(start, 1'b0, 1'b0, blank);
        if (live) begin
          live_items++;
          if (p == 1 && live_items == PHASE_ITEMS / 2) settle(1'b0);
        end
      end
    end

    settle(1'b1);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/stg_pkg.sv
src/stg_quarter_rom.sv
src/stg_sine_pipe.sv
src/sine_tone_generator_unit.sv
sim/testbench.sv
